@@ design/wgas_pkg.sv @@
// Shared types and constants for the windowed global alignment score pipeline.
package wgas_pkg;

   localparam int FIELD_BASES = 12;
   localparam int BASE_W      = 2;
   localparam int BASES_W     = FIELD_BASES * BASE_W;
   localparam int LEN_W       = 4;
   localparam int SUM_W       = LEN_W + 1;
   localparam int SCORE_W     = 6;

   typedef logic signed [SCORE_W-1:0] score_type;

   localparam score_type SC_MATCH    = 6'sd1;
   localparam score_type SC_MISMATCH = -6'sd1;
   localparam score_type SC_GAP      = -6'sd1;

   typedef struct packed {
      logic [BASES_W-1:0] query_bases;
      logic [BASES_W-1:0] ref_bases;
      logic [LEN_W-1:0]   query_len;
      logic [LEN_W-1:0]   ref_len;
      score_type          score;
   } item_type;

endpackage

@@ design/wgas_stage.sv @@
// One anti-diagonal of the alignment matrix, registered, with valid/stall flow.
module wgas_stage import wgas_pkg::*; #(
   parameter int EFF  = 12,
   parameter int DIAG = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_stall,
   input  item_type                    up_item,
   input  logic [EFF:0][SCORE_W-1:0]   up_d1,
   input  logic [EFF:0][SCORE_W-1:0]   up_d2,
   output logic                        dn_valid,
   input  logic                        dn_stall,
   output item_type                    dn_item,
   output logic [EFF:0][SCORE_W-1:0]   dn_d1,
   output logic [EFF:0][SCORE_W-1:0]   dn_d2
);

   localparam int IDX_W = (EFF < 2) ? 1 : $clog2(EFF + 1);

   logic                      valid_ff;
   item_type                  item_ff, item_in;
   logic [EFF:0][SCORE_W-1:0] d1_ff, d2_ff, cell_w;
   logic [SUM_W-1:0]          len_sum;
   logic [IDX_W-1:0]          end_idx;

   // cell i of this diagonal is H[i][DIAG-i]
   for (genvar gi = 0; gi <= EFF; gi++) begin : g_cell
      localparam int GJ = DIAG - gi;
      if (GJ < 0 || GJ > EFF) begin : g_off
         assign cell_w[gi] = '0;
      end else if (gi == 0 || GJ == 0) begin : g_edge
         assign cell_w[gi] = SCORE_W'(-DIAG);
      end else begin : g_core
         score_type diag_s, top_s, left_s, best_s;
         always_comb begin
            diag_s = $signed(up_d2[gi-1]) +
                     ((up_item.query_bases[BASE_W*(gi-1) +: BASE_W] ==
                       up_item.ref_bases[BASE_W*(GJ-1) +: BASE_W]) ? SC_MATCH : SC_MISMATCH);
            top_s  = $signed(up_d1[gi-1]) + SC_GAP;
            left_s = $signed(up_d1[gi]) + SC_GAP;
            best_s = diag_s;
            if (top_s > best_s) begin
               best_s = top_s;
            end
            if (left_s > best_s) begin
               best_s = left_s;
            end
         end
         assign cell_w[gi] = best_s;
      end
   end

   // take the end cell when the diagonal passes it
   always_comb begin
      len_sum = {1'b0, up_item.query_len} + {1'b0, up_item.ref_len};
      end_idx = up_item.query_len[IDX_W-1:0];
      item_in = up_item;
      if (len_sum == SUM_W'(DIAG)) begin
         item_in.score = cell_w[end_idx];
      end
   end

   assign up_stall = valid_ff && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         item_ff <= item_in;
         d1_ff   <= cell_w;
         d2_ff   <= up_d1;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;
   assign dn_d1    = d1_ff;
   assign dn_d2    = d2_ff;

endmodule

@@ design/windowed_global_alignment_score.sv @@
// Top level: global alignment score of two DNA windows, one anti-diagonal per stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  req     | in        | req_valid/req_stall  | query_bases, query_len, ref_bases, ref_len
//  rsp     | out       | rsp_valid/rsp_stall  | score (signed)
//
// Takes one item every cycle while req_stall is low; each item passes through one
// register stage per anti-diagonal of the score matrix.
// Reset clears the stage valid bits only; payload registers are left as they are.
// A stall on rsp holds the last stage; earlier stages keep moving into empty slots,
// so req_stall rises only once every stage holds an item.
module windowed_global_alignment_score import wgas_pkg::*; #(
   parameter int WINDOW = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BASES_W-1:0] req_query_bases,
   input  logic [LEN_W-1:0]   req_query_len,
   input  logic [BASES_W-1:0] req_ref_bases,
   input  logic [LEN_W-1:0]   req_ref_len,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SCORE_W-1:0] rsp_score
);

   // lengths cannot exceed what the base fields carry
   localparam int EFF = (WINDOW < FIELD_BASES) ? WINDOW : FIELD_BASES;
   localparam int NST = 2 * EFF - 1;

   logic                      valid_w [NST+1];
   logic                      stall_w [NST+1];
   item_type                  item_w  [NST+1];
   logic [EFF:0][SCORE_W-1:0] d1_w    [NST+1];
   logic [EFF:0][SCORE_W-1:0] d2_w    [NST+1];

   logic [LEN_W-1:0] qlen_clamp, rlen_clamp;
   logic [SUM_W-1:0] entry_sum;

   // clamp lengths and seed the first two diagonals
   always_comb begin
      qlen_clamp = (req_query_len > LEN_W'(EFF)) ? LEN_W'(EFF) : req_query_len;
      rlen_clamp = (req_ref_len > LEN_W'(EFF)) ? LEN_W'(EFF) : req_ref_len;
      entry_sum  = {1'b0, qlen_clamp} + {1'b0, rlen_clamp};

      item_w[0].query_bases = req_query_bases;
      item_w[0].ref_bases   = req_ref_bases;
      item_w[0].query_len   = qlen_clamp;
      item_w[0].ref_len     = rlen_clamp;
      // both empty scores zero, one base against nothing scores a single gap
      item_w[0].score       = (entry_sum == SUM_W'(1)) ? SC_GAP : '0;

      for (int i = 0; i <= EFF; i++) begin
         d1_w[0][i] = SC_GAP;
         d2_w[0][i] = '0;
      end
   end

   assign valid_w[0] = req_valid;
   assign req_stall  = stall_w[0];

   // advance one anti-diagonal per stage, diagonals 2 up to 2*EFF
   for (genvar gs = 0; gs < NST; gs++) begin : g_stage
      wgas_stage #(
         .EFF  (EFF),
         .DIAG (gs + 2)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_w[gs]),
         .up_stall (stall_w[gs]),
         .up_item  (item_w[gs]),
         .up_d1    (d1_w[gs]),
         .up_d2    (d2_w[gs]),
         .dn_valid (valid_w[gs+1]),
         .dn_stall (stall_w[gs+1]),
         .dn_item  (item_w[gs+1]),
         .dn_d1    (d1_w[gs+1]),
         .dn_d2    (d2_w[gs+1])
      );
   end

   // last stage doubles as the output register
   assign stall_w[NST] = rsp_stall;
   assign rsp_valid    = valid_w[NST];
   assign rsp_score    = item_w[NST].score;

   // input is held back only when the output is blocked
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked output");

   // score lies between minus the total length and the shorter length
   a_score_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($signed({rsp_score[SCORE_W-1], rsp_score}) +
          $signed({2'b00, item_w[NST].query_len} + {2'b00, item_w[NST].ref_len})
          >= $signed(7'd0)) &&
         ($signed(rsp_score) <= $signed({2'b00, item_w[NST].query_len})) &&
         ($signed(rsp_score) <= $signed({2'b00, item_w[NST].ref_len})))
      else $error("score outside the bounds set by the window lengths");

   // nothing leaves in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

@@ tb/windowed_global_alignment_score_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the windowed global alignment score pipeline.
module windowed_global_alignment_score_test;
   import wgas_pkg::*;

   localparam int WINDOW_BASES = 12;
   localparam int LIMIT_BASES  = (WINDOW_BASES < FIELD_BASES) ? WINDOW_BASES : FIELD_BASES;
   localparam int RANDOM_PAIRS = 1200;
   localparam int DRAIN_CYCLES = 2 * LIMIT_BASES + 8;
   localparam int PLAN_ROWS    = 19;

   // one row of the directed plan; 'typed' rows carry a hand-worked score
   typedef struct packed {
      logic [BASES_W-1:0] qb;
      logic [LEN_W-1:0]   ql;
      logic [BASES_W-1:0] rb;
      logic [LEN_W-1:0]   rl;
      bit                 typed;
      score_type          want;
   } window_pair_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [BASES_W-1:0] req_query_bases = '0;
   logic [LEN_W-1:0]   req_query_len = '0;
   logic [BASES_W-1:0] req_ref_bases = '0;
   logic [LEN_W-1:0]   req_ref_len = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [SCORE_W-1:0] rsp_score;

   // scores still owed by the block, oldest first
   score_type       pending_scores[$];
   int              mismatches = 0;
   bit              steady = 1'b0;
   window_pair_type plan[PLAN_ROWS];

   windowed_global_alignment_score #(.WINDOW(WINDOW_BASES)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_query_bases (req_query_bases),
      .req_query_len   (req_query_len),
      .req_ref_bases   (req_ref_bases),
      .req_ref_len     (req_ref_len),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_score       (rsp_score)
   );

   always #6 clock = ~clock;

   // Linear-gap Needleman-Wunsch over the clamped windows, one row kept at a time.
   function automatic score_type nw_score(input logic [BASES_W-1:0] qb,
                                          input logic [LEN_W-1:0]   ql_raw,
                                          input logic [BASES_W-1:0] rb,
                                          input logic [LEN_W-1:0]   rl_raw);
      int row[FIELD_BASES+1];
      int ql;
      int rl;
      int diag_prev;
      int top;
      int left;
      int diag;
      int best;
      logic [BASE_W-1:0] qc;
      ql = (int'(ql_raw) > LIMIT_BASES) ? LIMIT_BASES : int'(ql_raw);
      rl = (int'(rl_raw) > LIMIT_BASES) ? LIMIT_BASES : int'(rl_raw);
      for (int j = 0; j <= rl; j++)
         row[j] = j * int'(SC_GAP);
      for (int i = 1; i <= ql; i++) begin
         diag_prev = row[0];
         qc = qb[BASE_W*(i-1) +: BASE_W];
         row[0] = i * int'(SC_GAP);
         for (int j = 1; j <= rl; j++) begin
            top  = row[j] + int'(SC_GAP);
            left = row[j-1] + int'(SC_GAP);
            diag = diag_prev + ((qc == rb[BASE_W*(j-1) +: BASE_W]) ?
                                int'(SC_MATCH) : int'(SC_MISMATCH));
            diag_prev = row[j];
            best = diag;
            if (left > best)
               best = left;
            if (top > best)
               best = top;
            row[j] = best;
         end
      end
      return score_type'(row[rl]);
   endfunction

   // Present one window pair from a falling edge, idling first at random, and
   // hold it until accepted; book its score at the accepting edge.
   task automatic offer_pair(input logic [BASES_W-1:0] qb, input logic [LEN_W-1:0] ql,
                             input logic [BASES_W-1:0] rb, input logic [LEN_W-1:0] rl,
                             input score_type want);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_query_bases <= qb;
      req_query_len   <= ql;
      req_ref_bases   <= rb;
      req_ref_len     <= rl;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_scores = {pending_scores, want};
   endtask

   // Back-pressure on the result side follows the same idling rate.
   always @(negedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 24);

   // Compare every accepted score with the oldest one owed.
   always @(posedge clock) begin
      score_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            $error("score: expected none, got %0d", $signed(rsp_score));
            mismatches++;
         end else begin
            owed = pending_scores.pop_front();
            if (rsp_score !== owed) begin
               $error("score: expected %0d, got %0d", owed, $signed(rsp_score));
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [BASES_W-1:0] qb;
      logic [BASES_W-1:0] rb;
      logic [LEN_W-1:0]   ql;
      logic [LEN_W-1:0]   rl;
      int                 k;

      // Directed rows: empty windows, full windows, clamped lengths,
      // junk above the valid bases, then a handful of mixed patterns.
      plan = '{
         '{24'h000000,  4'd0, 24'h000000,  4'd0, 1'b1,   6'sd0},
         '{24'hFFFFFF, 4'd12, 24'h000000,  4'd0, 1'b1, -6'sd12},
         '{24'h000000,  4'd0, 24'hFFFFFF, 4'd12, 1'b1, -6'sd12},
         '{24'hFFFFFF, 4'd12, 24'hFFFFFF, 4'd12, 1'b1,  6'sd12},
         '{24'h000000, 4'd12, 24'hFFFFFF, 4'd12, 1'b1, -6'sd12},
         '{24'hFFFFFF, 4'd15, 24'hFFFFFF, 4'd15, 1'b1,  6'sd12},
         '{24'h555555, 4'd13, 24'h000000,  4'd0, 1'b1, -6'sd12},
         '{24'hFFFFFC,  4'd1, 24'hFFFFFC,  4'd1, 1'b1,   6'sd1},
         '{24'h000001,  4'd1, 24'h000002,  4'd1, 1'b1,  -6'sd1},
         '{24'hABCDEF,  4'd5, 24'h000000,  4'd0, 1'b1,  -6'sd5},
         '{24'h000000,  4'd0, 24'h123456, 4'd14, 1'b1, -6'sd12},
         '{24'hFFFFFF, 4'd12, 24'hFFFFFF,  4'd1, 1'b1, -6'sd10},
         '{24'h1B1B1B, 4'd12, 24'h6C6C6C, 4'd12, 1'b0,   6'sd0},
         '{24'hE4E4E4,  4'd7, 24'h4E4E4E,  4'd9, 1'b0,   6'sd0},
         '{24'h123456, 4'd10, 24'h234561, 4'd10, 1'b0,   6'sd0},
         '{24'hAAAAAA, 4'd12, 24'h555555, 4'd11, 1'b0,   6'sd0},
         '{24'h0F0F0F,  4'd6, 24'h0F0F0F,  4'd8, 1'b0,   6'sd0},
         '{24'h39C39C, 4'd15, 24'h9C39C3, 4'd12, 1'b0,   6'sd0},
         '{24'hFEDCBA,  4'd3, 24'hFEDCBA, 4'd12, 1'b0,   6'sd0}
      };

      // hold reset, then release it on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r])
         offer_pair(plan[r].qb, plan[r].ql, plan[r].rb, plan[r].rl,
                    plan[r].typed ? plan[r].want
                                  : nw_score(plan[r].qb, plan[r].ql, plan[r].rb, plan[r].rl));

      // Random pairs. Most are related windows (a few substitutions, or a one-base
      // shift) so that scores reach the high end; the rest are unrelated noise.
      // A stretch in the middle runs with no idling on either side.
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         steady = (n >= 400 && n < 700);
         qb = BASES_W'($urandom);
         ql = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15))
                                       : LEN_W'($urandom_range(LIMIT_BASES));
         case ($urandom_range(3))
            0: begin
               rb = qb;
               repeat ($urandom_range(3)) begin
                  k = $urandom_range(FIELD_BASES - 1);
                  rb[BASE_W*k +: BASE_W] ^= BASE_W'($urandom_range(1, 3));
               end
               rl = ql;
            end
            1: begin
               rb = {qb[BASES_W-BASE_W-1:0], BASE_W'($urandom)};
               rl = (ql < LIMIT_BASES) ? ql + 4'd1 : ql;
            end
            2: begin
               rb = {BASE_W'($urandom), qb[BASES_W-1:BASE_W]};
               rl = (ql > 0) ? ql - 4'd1 : ql;
            end
            default: begin
               rb = BASES_W'($urandom);
               rl = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15))
                                             : LEN_W'($urandom_range(LIMIT_BASES));
            end
         endcase
         offer_pair(qb, ql, rb, rl, nw_score(qb, ql, rb, rl));
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then keep clocking to catch stray results
      while (pending_scores.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("windowed_global_alignment_score_test passed");
      else
         $display("windowed_global_alignment_score_test failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("windowed_global_alignment_score_test failed");
      $finish;
   end

endmodule

@@ files.f @@
design/wgas_pkg.sv
design/wgas_stage.sv
design/windowed_global_alignment_score.sv
tb/windowed_global_alignment_score_test.sv
